// File: rtl/core/esac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esac_pkg: shared types for the Euler step and box collision block
// Payload structs, opcodes, state encoding and controller/datapath signals.
// ----------------------------------------------------------------------------
package esac_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;
  localparam int ResultLimit = 16;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [30:0]        width;
    logic [30:0]        height;
    logic [15:0]        dt;
  } esac_in_t;

  typedef struct packed {
    logic [3:0]         body;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               hit;
    logic [3:0]         partner;
    logic               last;
  } esac_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VREAD,
    ST_VEL,
    ST_PREAD,
    ST_POS,
    ST_TEST,
    ST_EMIT
  } esac_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // write the input item into its slot
    logic latch_dt;   // capture dt of the accepted item
    logic rd_body;    // read body i into the working registers
    logic wr_vel;     // update velocity of body i
    logic wr_pos;     // update position of body i
    logic clr_hit;    // start the partner search of body i
    logic test;       // test body i against body j
    logic emit;       // present the result of body i
  } esac_cmd_t;

endpackage

// File: rtl/core/euler_step_aabb_collide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_step_aabb_collide: body table with Euler step and box collision
//
//   channel  signals                       flow
//   cmd      start, busy, in_item          start && !busy accepts an item
//   cfg      cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready writes
//   result   strobe, result                one-cycle strobe per body, no stall
//
// A load item is written into its slot when accepted. A step item runs the
// states VREAD, VEL, PREAD and POS per body to integrate, then per body tests
// partners in TEST until a hit or the last body and emits a result in EMIT;
// the shared x and y multipliers and the sequential pair test set its length.
// Synchronous reset clears control and the body count; the table is not
// cleared. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module euler_step_aabb_collide #(
  parameter int MAX_BODIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  esac_pkg::esac_in_t   in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_data,
  output logic                 strobe,
  output esac_pkg::esac_out_t  result
);
  import esac_pkg::*;

  localparam int IW = $clog2(MAX_BODIES);

  logic [4:0] entity_count;
  esac_cmd_t cmd;
  logic [IW-1:0] idx_i, idx_j;
  logic last, found, go;

  assign cfg_ready = 1'b1;
  assign go = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) entity_count <= '0;
    else if (cfg_valid && cfg_ready) entity_count <= cfg_data;
  end

  esac_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
    .clk, .rst, .start(go), .opcode(in_item.opcode), .entity_count,
    .found, .busy, .idx_i, .idx_j, .last, .cmd
  );

  esac_dp #(.MAX_BODIES(MAX_BODIES)) u_dp (
    .clk, .rst, .in_item, .cmd, .idx_i, .idx_j, .last, .found,
    .strobe, .result
  );
endmodule

// File: rtl/core/esac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esac_ctrl: sequencer of the Euler step and box collision block
// Walks the integrate pass, then the pairwise test and result pass.
// ----------------------------------------------------------------------------
module esac_ctrl #(
  parameter int MAX_BODIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           opcode,
  input  logic [4:0]                     entity_count,
  input  logic                           found,
  output logic                           busy,
  output logic [$clog2(MAX_BODIES)-1:0]  idx_i,
  output logic [$clog2(MAX_BODIES)-1:0]  idx_j,
  output logic                           last,
  output esac_pkg::esac_cmd_t            cmd
);
  import esac_pkg::*;

  localparam int IW = $clog2(MAX_BODIES);
  localparam int Lim = (MAX_BODIES < ResultLimit) ? MAX_BODIES : ResultLimit;
  localparam int CW = $clog2(Lim + 1);

  esac_state_t state, state_next;
  logic [CW-1:0] active;
  logic [CW-1:0] cnt_i, cnt_j;
  logic [CW-1:0] lim_c;
  logic last_i, last_j;

  assign lim_c = CW'(Lim);
  always_comb begin
    if (entity_count > 5'(Lim))
      active = lim_c;
    else
      active = CW'(entity_count);
  end

  assign last_i = (cnt_i + CW'(1) == active);
  assign last_j = (cnt_j + CW'(1) == active);
  assign idx_i = IW'(cnt_i);
  assign idx_j = IW'(cnt_j);
  assign last = last_i;
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt_i <= '0;
      cnt_j <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt_i <= '0;
          cnt_j <= '0;
        end
        ST_POS: cnt_i <= last_i ? '0 : cnt_i + CW'(1);
        ST_TEST: cnt_j <= cnt_j + CW'(1);
        ST_EMIT: begin
          cnt_i <= cnt_i + CW'(1);
          cnt_j <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (start && opcode == OP_STEP && active != '0) state_next = ST_VREAD;
      ST_VREAD: state_next = ST_VEL;
      ST_VEL:   state_next = ST_PREAD;
      ST_PREAD: state_next = ST_POS;
      ST_POS:   state_next = last_i ? ST_TEST : ST_VREAD;
      ST_TEST: begin
        // Self pairs are skipped inside the datapath's search.
        if (found || last_j) state_next = ST_EMIT;
      end
      ST_EMIT:  state_next = last_i ? ST_IDLE : ST_TEST;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = start && opcode == OP_LOAD;
        cmd.latch_dt = start;
        cmd.clr_hit = 1'b1;
      end
      ST_VREAD: cmd.rd_body = 1'b1;
      ST_VEL:   cmd.wr_vel = 1'b1;
      ST_PREAD: cmd.rd_body = 1'b1;
      ST_POS:   cmd.wr_pos = 1'b1;
      ST_TEST:  cmd.test = 1'b1;
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.clr_hit = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/core/esac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esac_dp: body table, Euler update unit and box overlap test
// Shared x and y multipliers; stores are register files read at two indices.
// ----------------------------------------------------------------------------
module esac_dp #(
  parameter int MAX_BODIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  esac_pkg::esac_in_t            in_item,
  input  esac_pkg::esac_cmd_t           cmd,
  input  logic [$clog2(MAX_BODIES)-1:0] idx_i,
  input  logic [$clog2(MAX_BODIES)-1:0] idx_j,
  input  logic                          last,
  output logic                          found,
  output logic                          strobe,
  output esac_pkg::esac_out_t           result
);
  import esac_pkg::*;

  localparam int IW = $clog2(MAX_BODIES);

  logic signed [31:0] px [MAX_BODIES];
  logic signed [31:0] py [MAX_BODIES];
  logic signed [31:0] vx [MAX_BODIES];
  logic signed [31:0] vy [MAX_BODIES];
  logic signed [31:0] fx [MAX_BODIES];
  logic signed [31:0] fy [MAX_BODIES];
  logic [30:0]        ew [MAX_BODIES];
  logic [30:0]        eh [MAX_BODIES];

  logic [15:0] dt;
  logic signed [31:0] base_x, base_y, rate_x, rate_y;
  logic signed [48:0] prod_x, prod_y;
  logic signed [32:0] sum_x, sum_y;
  logic signed [31:0] sat_x, sat_y;
  logic hit;
  logic [IW-1:0] partner;
  logic overlap;
  logic slot_ok;
  logic [IW-1:0] slot_idx;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Arithmetic shift of the exact product is floor division by 65536.
  assign prod_x = rate_x * $signed({1'b0, dt});
  assign prod_y = rate_y * $signed({1'b0, dt});
  assign sum_x = 33'(base_x) + 33'(prod_x >>> 16);
  assign sum_y = 33'(base_y) + 33'(prod_y >>> 16);
  assign sat_x = sat32(sum_x);
  assign sat_y = sat32(sum_y);

  assign slot_ok = ({28'd0, in_item.slot} < 32'(MAX_BODIES));
  assign slot_idx = IW'(in_item.slot);

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      px[slot_idx] <= in_item.pos_x;
      py[slot_idx] <= in_item.pos_y;
      vx[slot_idx] <= in_item.vel_x;
      vy[slot_idx] <= in_item.vel_y;
      fx[slot_idx] <= in_item.force_x;
      fy[slot_idx] <= in_item.force_y;
      ew[slot_idx] <= in_item.width;
      eh[slot_idx] <= in_item.height;
    end
    if (cmd.latch_dt) dt <= in_item.dt;
    if (cmd.wr_vel) begin
      vx[idx_i] <= sat_x;
      vy[idx_i] <= sat_y;
    end
    if (cmd.wr_pos) begin
      px[idx_i] <= sat_x;
      py[idx_i] <= sat_y;
    end
  end

  // Operand selection: the velocity pass uses force, the position pass
  // uses the freshly written velocity.
  logic phase_pos;
  always_ff @(posedge clk) begin
    if (rst) phase_pos <= 1'b0;
    else if (cmd.wr_vel) phase_pos <= 1'b1;
    else if (cmd.wr_pos) phase_pos <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_body) begin
      if (phase_pos) begin
        base_x <= px[idx_i];
        base_y <= py[idx_i];
        rate_x <= vx[idx_i];
        rate_y <= vy[idx_i];
      end else begin
        base_x <= vx[idx_i];
        base_y <= vy[idx_i];
        rate_x <= fx[idx_i];
        rate_y <= fy[idx_i];
      end
    end
  end

  always_comb begin
    logic signed [32:0] ax, ay, bx, by;
    ax = 33'(px[idx_i]);
    ay = 33'(py[idx_i]);
    bx = 33'(px[idx_j]);
    by = 33'(py[idx_j]);
    overlap = (ax + 33'($signed({1'b0, ew[idx_i]})) >= bx)
           && (ax <= bx + 33'($signed({1'b0, ew[idx_j]})))
           && (ay + 33'($signed({1'b0, eh[idx_i]})) >= by)
           && (ay <= by + 33'($signed({1'b0, eh[idx_j]})));
  end

  assign found = cmd.test && overlap && (idx_i != idx_j);

  always_ff @(posedge clk) begin
    if (cmd.clr_hit) begin
      hit <= 1'b0;
      partner <= '0;
    end else if (found && !hit) begin
      hit <= 1'b1;
      partner <= idx_j;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.body <= 4'(idx_i);
      result.new_pos_x <= px[idx_i];
      result.new_pos_y <= py[idx_i];
      result.new_vel_x <= vx[idx_i];
      result.new_vel_y <= vy[idx_i];
      result.hit <= hit;
      result.partner <= 4'(partner);
      result.last <= last;
    end
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Euler step and box collision block
// Loads body slots, advances time steps and checks every body result
// against an in-bench model of the integration and the pairwise box test.
// ----------------------------------------------------------------------------
module tb;
  import esac_pkg::*;

  localparam int NB = 16;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  esac_in_t  in_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [4:0] cfg_data;
  logic      strobe;
  esac_out_t result;

  euler_step_aabb_collide dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  // Model state of the body table.
  logic signed [31:0] m_px[NB], m_py[NB], m_vx[NB], m_vy[NB], m_fx[NB], m_fy[NB];
  logic [30:0]        m_w[NB], m_h[NB];
  int                 m_count;

  esac_in_t  pending_items[$];
  esac_out_t expected_bodies[$];
  int        errors;
  int        n_steps, n_results, n_hits;
  int        send_idle_pct;
  logic [4:0] cfg_req;
  bit        cfg_pend;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] euler_add(logic signed [31:0] base,
                                                   logic signed [31:0] rate,
                                                   logic [15:0] dt);
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    prod = 64'(rate) * $signed({48'd0, dt});
    sum = 64'(base) + (prod >>> 16);
    if (sum > 64'sd2147483647) return 32'sh7fffffff;
    if (sum < -64'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  function automatic bit boxes_overlap(int a, int b);
    logic signed [63:0] ax, ay, bx, by;
    ax = 64'(m_px[a]); ay = 64'(m_py[a]);
    bx = 64'(m_px[b]); by = 64'(m_py[b]);
    return (ax + $signed({33'd0, m_w[a]}) >= bx) && (ax <= bx + $signed({33'd0, m_w[b]})) &&
           (ay + $signed({33'd0, m_h[a]}) >= by) && (ay <= by + $signed({33'd0, m_h[b]}));
  endfunction

  task automatic predict_item(esac_in_t it);
    int active;
    esac_out_t r;
    if (it.opcode == OP_LOAD) begin
      m_px[it.slot] = it.pos_x; m_py[it.slot] = it.pos_y;
      m_vx[it.slot] = it.vel_x; m_vy[it.slot] = it.vel_y;
      m_fx[it.slot] = it.force_x; m_fy[it.slot] = it.force_y;
      m_w[it.slot] = it.width; m_h[it.slot] = it.height;
      return;
    end
    n_steps++;
    active = (m_count > NB) ? NB : m_count;
    for (int i = 0; i < active; i++) begin
      m_vx[i] = euler_add(m_vx[i], m_fx[i], it.dt);
      m_vy[i] = euler_add(m_vy[i], m_fy[i], it.dt);
      m_px[i] = euler_add(m_px[i], m_vx[i], it.dt);
      m_py[i] = euler_add(m_py[i], m_vy[i], it.dt);
    end
    for (int i = 0; i < active; i++) begin
      r = '0;
      r.body = i[3:0];
      r.new_pos_x = m_px[i]; r.new_pos_y = m_py[i];
      r.new_vel_x = m_vx[i]; r.new_vel_y = m_vy[i];
      for (int j = 0; j < active; j++) begin
        if (j != i && boxes_overlap(i, j)) begin
          r.hit = 1'b1;
          r.partner = j[3:0];
          break;
        end
      end
      r.last = (i + 1 == active);
      expected_bodies.push_back(r);
    end
  endtask

  // Driver: one item from the queue when the block is free, with random idle gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) predict_item(in_item);
      if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Configuration channel.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      m_count = cfg_data;
      cfg_pend = 1'b0;
    end else if (cfg_pend && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_data <= cfg_req;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    esac_out_t e;
    if (!rst && strobe) begin
      n_results++;
      if (result.hit) n_hits++;
      if (expected_bodies.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        e = expected_bodies.pop_front();
        if (result.body !== e.body || result.new_pos_x !== e.new_pos_x ||
            result.new_pos_y !== e.new_pos_y || result.new_vel_x !== e.new_vel_x ||
            result.new_vel_y !== e.new_vel_y || result.hit !== e.hit ||
            result.partner !== e.partner || result.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, result);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_q(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(32'h00200000, 0)) - 32'sh00100000;
    endcase
  endfunction

  function automatic esac_in_t make_load(int s, bit wild);
    esac_in_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.slot = s[3:0];
    it.pos_x = rand_q(wild ? $urandom_range(3, 0) : 3);
    it.pos_y = rand_q(wild ? $urandom_range(3, 0) : 3);
    it.vel_x = rand_q(wild ? $urandom_range(3, 0) : 3);
    it.vel_y = rand_q(wild ? $urandom_range(3, 0) : 3);
    it.force_x = rand_q(wild ? $urandom_range(3, 0) : 3);
    it.force_y = rand_q(wild ? $urandom_range(3, 0) : 3);
    it.width = wild ? 31'($urandom()) : 31'($urandom_range(32'h00080000, 0));
    it.height = wild ? 31'($urandom()) : 31'($urandom_range(32'h00080000, 0));
    it.dt = 16'($urandom());
    return it;
  endfunction

  function automatic esac_in_t make_step(logic [15:0] dt);
    esac_in_t it;
    it = make_load(0, 1'b1);
    it.opcode = OP_STEP;
    it.slot = 4'($urandom());
    it.dt = dt;
    return it;
  endfunction

  // Waits until every queued item is accepted and every result has come.
  task automatic drain();
    while (pending_items.size() > 0 || start || expected_bodies.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_count(int n);
    cfg_req = n[4:0];
    cfg_pend = 1'b1;
    while (cfg_pend) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_phase(int n_items, int idle);
    int cnt;
    send_idle_pct = idle;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(9, 0) == 0) begin
        cnt = ($urandom_range(3, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(6, 0);
        drain();
        for (int s = 0; s < NB && s < cnt; s++) pending_items.push_back(make_load(s, 1'b0));
        drain();
        set_count(cnt);
      end
      if ($urandom_range(2, 0) == 0)
        pending_items.push_back(make_load($urandom_range(NB - 1, 0), $urandom_range(1, 0)));
      else
        pending_items.push_back(make_step(16'($urandom())));
    end
    drain();
  endtask

  initial begin
    esac_in_t it;
    rst = 1'b1; start = 1'b0; in_item = '0; cfg_valid = 1'b0; cfg_data = '0;
    cfg_pend = 1'b0; errors = 0; n_steps = 0; n_results = 0; n_hits = 0;
    m_count = 0; send_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a step with no active bodies, then extremes and saturation.
    pending_items.push_back(make_step(16'hffff));
    for (int s = 0; s < NB; s++) begin
      it = make_load(s, 1'b1);
      if (s == 0) begin
        it.pos_x = 32'sh7fffffff; it.vel_x = 32'sh7fffffff; it.force_x = 32'sh7fffffff;
        it.pos_y = 32'sh80000000; it.vel_y = 32'sh80000000; it.force_y = 32'sh80000000;
        it.width = '1; it.height = '1;
      end
      if (s == 1 || s == 2) begin
        // Identical twins must collide with each other.
        it.pos_x = 32'sh00010000; it.pos_y = -32'sh00010000; it.vel_x = 0; it.vel_y = 0;
        it.force_x = -1; it.force_y = 1; it.width = 0; it.height = 0;
      end
      pending_items.push_back(it);
    end
    drain();
    set_count(16);
    pending_items.push_back(make_step(16'hffff));
    pending_items.push_back(make_step(16'h0000));
    pending_items.push_back(make_step(16'h0001));
    drain();
    set_count(31);
    pending_items.push_back(make_step(16'h8000));
    drain();
    set_count(1);
    pending_items.push_back(make_step(16'h1234));
    drain();
    set_count(0);
    pending_items.push_back(make_step(16'h4321));
    drain();
    set_count(16);

    random_phase(45, 12);
    random_phase(45, 50);
    random_phase(45, 0);

    $display("Covered %0d step items giving %0d results (%0d with a hit), counts 0..31.",
             n_steps, n_results, n_hits);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
